[hdl/tts_pkg.sv]
// Shared types and constants for the tick task scheduler.
// Holds the task table record, the controller state encoding and the code points.
// No dependencies.
package tts_pkg;

   // field widths fixed by the interface
   localparam int TICK_W = 20;
   localparam int ID_W   = 8;
   localparam int TIME_W = 16;
   localparam int PRIO_W = 8;

   localparam logic [TICK_W-1:0] TICK_MAX = 20'hFFFFF;

   // item operations
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // selection policies
   localparam logic [1:0] POL_FIFO = 2'd0;
   localparam logic [1:0] POL_SRTF = 2'd1;
   localparam logic [1:0] POL_PRIO = 2'd2;
   localparam logic [1:0] POL_NONE = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_TICK   = 2'd0;
   localparam logic [1:0] STATUS_LOADED = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   // one task table entry, as held in the table RAM
   typedef struct packed {
      logic [ID_W-1:0]   ident;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] prio;
      logic [TICK_W-1:0] start;
      logic              started;
      logic              done;
   } task_entry_type;

   // controls from the sequencer to the picker
   typedef struct packed {
      logic clear;
      logic sample;
   } pick_ctrl_type;

   // completion figures of a finished task
   typedef struct packed {
      logic [TICK_W-1:0] comp;
      logic [TICK_W-1:0] turn;
      logic [TICK_W-1:0] wait_time;
      logic [TICK_W-1:0] resp;
   } metrics_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_CALC1,
      ST_CALC2,
      ST_CALC3,
      ST_COMMIT
   } sched_state_type;

endpackage

[hdl/tts_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tts_picker.sv]
// Running minimum over the table entries streamed out of the task RAM.
// Depends on tts_pkg.
module tts_picker #(
   parameter int MAX_TASKS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tts_pkg::pick_ctrl_type          ctrl,
   input  logic [1:0]                      policy,
   input  logic [tts_pkg::TICK_W-1:0]      tick,
   input  logic [$clog2(MAX_TASKS)-1:0]    rd_slot,
   input  tts_pkg::task_entry_type         rd_entry,
   output logic                            found,
   output logic [$clog2(MAX_TASKS)-1:0]    best_slot,
   output tts_pkg::task_entry_type         best_entry
);
   import tts_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);

   logic                 found_ff, found_in;
   logic [TIME_W-1:0]    best_key_ff;
   logic [IDX_W-1:0]     best_slot_ff;
   task_entry_type       best_entry_ff;
   logic [TIME_W-1:0]    key;
   logic                 eligible;
   logic                 take;

   // sort key of the entry on the read port
   always_comb begin
      case (policy)
         POL_FIFO: key = rd_entry.arrival;
         POL_SRTF: key = rd_entry.remaining;
         default:  key = TIME_W'(rd_entry.prio);
      endcase
   end

   // arrived, not done, and strictly better (ties keep the lower slot)
   assign eligible = !rd_entry.done && (TICK_W'(rd_entry.arrival) <= tick);
   assign take     = ctrl.sample && eligible && (!found_ff || (key < best_key_ff));

   always_comb begin
      found_in = found_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   // best candidate so far
   always_ff @(posedge clock) begin
      if (take) begin
         best_key_ff   <= key;
         best_slot_ff  <= rd_slot;
         best_entry_ff <= rd_entry;
      end
   end

   assign found      = found_ff;
   assign best_slot  = best_slot_ff;
   assign best_entry = best_entry_ff;

endmodule

[hdl/tts_metrics.sv]
// Three stage pipeline working out completion, turnaround, waiting and response.
// Depends on tts_pkg.
module tts_metrics (
   input  logic                        clock,
   input  logic [tts_pkg::TICK_W-1:0]  tick,
   input  logic [tts_pkg::TIME_W-1:0]  arrival,
   input  logic [tts_pkg::TIME_W-1:0]  burst,
   input  logic [tts_pkg::TICK_W-1:0]  start,
   output tts_pkg::metrics_type        result
);
   import tts_pkg::*;

   logic [TICK_W-1:0] comp1_ff, comp1_in;
   logic [TICK_W-1:0] resp1_ff, resp1_in;
   logic [TICK_W-1:0] arr1_ff;
   logic [TICK_W-1:0] burst1_ff;
   logic [TICK_W-1:0] comp2_ff;
   logic [TICK_W-1:0] resp2_ff;
   logic [TICK_W-1:0] turn2_ff, turn2_in;
   logic [TICK_W-1:0] burst2_ff;
   logic [TICK_W-1:0] wait3_ff, wait3_in;
   logic [TICK_W-1:0] comp3_ff;
   logic [TICK_W-1:0] turn3_ff;
   logic [TICK_W-1:0] resp3_ff;

   // stage 1: saturating completion tick, response time
   assign comp1_in = (tick == TICK_MAX) ? TICK_MAX : tick + 1'b1;
   assign resp1_in = (start >= TICK_W'(arrival)) ? start - TICK_W'(arrival) : '0;

   // stage 2: turnaround
   assign turn2_in = comp1_ff - arr1_ff;

   // stage 3: waiting, clamped at zero
   assign wait3_in = (turn2_ff > burst2_ff) ? turn2_ff - burst2_ff : '0;

   always_ff @(posedge clock) begin
      comp1_ff  <= comp1_in;
      resp1_ff  <= resp1_in;
      arr1_ff   <= TICK_W'(arrival);
      burst1_ff <= TICK_W'(burst);
      comp2_ff  <= comp1_ff;
      resp2_ff  <= resp1_ff;
      turn2_ff  <= turn2_in;
      burst2_ff <= burst1_ff;
      comp3_ff  <= comp2_ff;
      resp3_ff  <= resp2_ff;
      turn3_ff  <= turn2_ff;
      wait3_ff  <= wait3_in;
   end

   assign result.comp      = comp3_ff;
   assign result.turn      = turn3_ff;
   assign result.wait_time = wait3_ff;
   assign result.resp      = resp3_ff;

endmodule

[hdl/tick_task_scheduler_core.sv]
// Tick task scheduler. Tasks are loaded into a RAM table one transaction at a time;
// each tick transaction streams the loaded entries out of the table, one per cycle,
// picks the arrived, unfinished task with the smallest key under the current policy,
// runs it for one tick and writes the entry back. A load's result is registered in the
// load state once the output register is free. A tick's result is registered after the
// scan state and the states ST_CALC1, ST_CALC2 and ST_CALC3, in the commit state once
// the output register is free. The selection scan walks the table through its single
// read port. The next transaction is taken in the cycle after a result is registered.
// A new transaction is accepted while the previous result still waits on the output
// register. Its own result is registered only once that one has gone. The policy
// register must only be written while idle.
// Depends on tts_pkg, tts_ram, tts_picker and tts_metrics.
module tick_task_scheduler_core #(
   parameter int MAX_TASKS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_policy,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [tts_pkg::ID_W-1:0]    req_task_id,
   input  logic [tts_pkg::TIME_W-1:0]  req_arrival,
   input  logic [tts_pkg::TIME_W-1:0]  req_burst,
   input  logic [tts_pkg::PRIO_W-1:0]  req_prio,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_ran,
   output logic [tts_pkg::ID_W-1:0]    rsp_running_id,
   output logic [tts_pkg::TICK_W-1:0]  rsp_tick_time,
   output logic                        rsp_finished,
   output logic [tts_pkg::TICK_W-1:0]  rsp_finish_tick,
   output logic [tts_pkg::TICK_W-1:0]  rsp_turnaround,
   output logic [tts_pkg::TICK_W-1:0]  rsp_waiting,
   output logic [tts_pkg::TICK_W-1:0]  rsp_response,
   output logic                        rsp_all_done
);
   import tts_pkg::*;

   localparam int IDX_W   = $clog2(MAX_TASKS);
   localparam int CNT_W   = $clog2(MAX_TASKS + 1);
   localparam int ENTRY_W = $bits(task_entry_type);

   sched_state_type  state_ff, state_in;

   logic [1:0]        policy_ff;
   logic [CNT_W-1:0]  loaded_count_ff, loaded_count_in;
   logic [CNT_W-1:0]  done_count_ff, done_count_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [CNT_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_slot_ff;

   // captured request
   logic              op_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] arrival_ff;
   logic [TIME_W-1:0] burst_ff;
   logic [PRIO_W-1:0] prio_ff;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff;
   logic              rsp_ran_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [TICK_W-1:0] rsp_tick_ff;
   logic              rsp_fin_ff;
   logic [TICK_W-1:0] rsp_comp_ff;
   logic [TICK_W-1:0] rsp_turn_ff;
   logic [TICK_W-1:0] rsp_wait_ff;
   logic [TICK_W-1:0] rsp_resp_ff;
   logic              rsp_all_done_ff;

   // decoded controls
   logic              req_accept;
   logic              out_free;
   logic              issue;
   logic              load_fire;
   logic              commit_fire;
   logic              load_ok;
   pick_ctrl_type     pick_ctrl;

   // table and picker signals
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   task_entry_type    ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;
   task_entry_type    rd_entry;
   logic              found;
   logic [IDX_W-1:0]  best_slot;
   task_entry_type    best_entry;
   task_entry_type    load_entry;
   task_entry_type    upd_entry;
   logic [TICK_W-1:0] start_eff;
   logic              fin;
   metrics_type       metrics;

   // task table
   tts_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_entry = task_entry_type'(ram_rdata);

   tts_picker #(
      .MAX_TASKS (MAX_TASKS)
   ) u_picker (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (pick_ctrl),
      .policy     (policy_ff),
      .tick       (tick_ff),
      .rd_slot    (rd_slot_ff),
      .rd_entry   (rd_entry),
      .found      (found),
      .best_slot  (best_slot),
      .best_entry (best_entry)
   );

   // first start tick is the current one if the task never ran before
   assign start_eff = best_entry.started ? best_entry.start : tick_ff;

   tts_metrics u_metrics (
      .clock   (clock),
      .tick    (tick_ff),
      .arrival (best_entry.arrival),
      .burst   (best_entry.burst),
      .start   (start_eff),
      .result  (metrics)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == OP_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!issue && !rd_vld_ff) begin
               state_in = ST_CALC1;
            end
         end
         ST_CALC1: state_in = ST_CALC2;
         ST_CALC2: state_in = ST_CALC3;
         ST_CALC3: state_in = ST_COMMIT;
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // decoded outputs of the sequencer
   always_comb begin
      req_accept       = (state_ff == ST_IDLE) && req_valid;
      issue            = (state_ff == ST_SCAN) && (scan_idx_ff < loaded_count_ff)
                         && (policy_ff != POL_NONE);
      load_fire        = (state_ff == ST_LOAD) && out_free;
      commit_fire      = (state_ff == ST_COMMIT) && out_free;
      pick_ctrl.clear  = req_accept;
      pick_ctrl.sample = (state_ff == ST_SCAN) && rd_vld_ff;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign load_ok   = (loaded_count_ff != CNT_W'(MAX_TASKS)) && (burst_ff != '0);

   // entry images written back to the table
   always_comb begin
      load_entry.ident     = id_ff;
      load_entry.arrival   = arrival_ff;
      load_entry.burst     = burst_ff;
      load_entry.remaining = burst_ff;
      load_entry.prio      = prio_ff;
      load_entry.start     = '0;
      load_entry.started   = 1'b0;
      load_entry.done      = 1'b0;

      fin                  = (best_entry.remaining == TIME_W'(1));
      upd_entry            = best_entry;
      upd_entry.remaining  = best_entry.remaining - 1'b1;
      upd_entry.started    = 1'b1;
      upd_entry.start      = start_eff;
      upd_entry.done       = fin;
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = best_slot;
      ram_wdata = upd_entry;
      if (load_fire) begin
         ram_we    = load_ok;
         ram_waddr = loaded_count_ff[IDX_W-1:0];
         ram_wdata = load_entry;
      end else if (commit_fire) begin
         ram_we    = found;
      end
   end

   // counters and tick
   always_comb begin
      loaded_count_in = loaded_count_ff;
      done_count_in   = done_count_ff;
      tick_in         = tick_ff;
      scan_idx_in     = scan_idx_ff;
      if (load_fire && load_ok) begin
         loaded_count_in = loaded_count_ff + 1'b1;
      end
      if (commit_fire) begin
         if (found && fin) begin
            done_count_in = done_count_ff + 1'b1;
         end
         if (tick_ff != TICK_MAX) begin
            tick_in = tick_ff + 1'b1;
         end
      end
      if (req_accept) begin
         scan_idx_in = '0;
      end else if (issue) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_fire || commit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         policy_ff       <= POL_FIFO;
         loaded_count_ff <= '0;
         done_count_ff   <= '0;
         tick_ff         <= '0;
         scan_idx_ff     <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         loaded_count_ff <= loaded_count_in;
         done_count_ff   <= done_count_in;
         tick_ff         <= tick_in;
         scan_idx_ff     <= scan_idx_in;
         rd_vld_ff       <= issue;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            policy_ff <= csr_policy;
         end
      end
   end

   // request capture and read slot tracking
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_operation;
         id_ff      <= req_task_id;
         arrival_ff <= req_arrival;
         burst_ff   <= req_burst;
         prio_ff    <= req_prio;
      end
      if (issue) begin
         rd_slot_ff <= scan_idx_ff[IDX_W-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (load_fire) begin
         rsp_status_ff   <= load_ok ? STATUS_LOADED : STATUS_REJECT;
         rsp_ran_ff      <= 1'b0;
         rsp_id_ff       <= '0;
         rsp_tick_ff     <= tick_ff;
         rsp_fin_ff      <= 1'b0;
         rsp_comp_ff     <= '0;
         rsp_turn_ff     <= '0;
         rsp_wait_ff     <= '0;
         rsp_resp_ff     <= '0;
         rsp_all_done_ff <= (done_count_ff == loaded_count_in);
      end else if (commit_fire) begin
         rsp_status_ff   <= STATUS_TICK;
         rsp_ran_ff      <= found;
         rsp_id_ff       <= found ? best_entry.ident : '0;
         rsp_tick_ff     <= tick_ff;
         rsp_fin_ff      <= found && fin;
         rsp_comp_ff     <= (found && fin) ? metrics.comp : '0;
         rsp_turn_ff     <= (found && fin) ? metrics.turn : '0;
         rsp_wait_ff     <= (found && fin) ? metrics.wait_time : '0;
         rsp_resp_ff     <= (found && fin) ? metrics.resp : '0;
         rsp_all_done_ff <= (done_count_in == loaded_count_ff);
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_ran             = rsp_ran_ff;
   assign rsp_running_id      = rsp_id_ff;
   assign rsp_tick_time       = rsp_tick_ff;
   assign rsp_finished        = rsp_fin_ff;
   assign rsp_finish_tick     = rsp_comp_ff;
   assign rsp_turnaround      = rsp_turn_ff;
   assign rsp_waiting         = rsp_wait_ff;
   assign rsp_response        = rsp_resp_ff;
   assign rsp_all_done        = rsp_all_done_ff;

   // the operation captured at acceptance matches the route the sequencer took
   a_op_route: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (op_ff == OP_LOAD))
      else $error("load state entered for a tick transaction");

   a_done_le_loaded: assert property (@(posedge clock) disable iff (reset)
      done_count_ff <= loaded_count_ff)
      else $error("more tasks done than loaded");

   a_pick_in_table: assert property (@(posedge clock) disable iff (reset)
      found |-> (CNT_W'(best_slot) < loaded_count_ff))
      else $error("picked slot beyond the loaded tasks");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(load_fire || commit_fire))
      else $error("response raised without a load or commit");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted transaction not taken up");

endmodule
